### hdl/lpud_pkg.sv
package lpud_pkg;

   // Allowed range of the next UTF-8 continuation byte
   typedef enum logic [2:0] {
      RANGE_80_BF = 3'd0,
      RANGE_A0_BF = 3'd1,
      RANGE_80_9F = 3'd2,
      RANGE_90_BF = 3'd3,
      RANGE_80_8F = 3'd4
   } range_type;

   typedef struct packed {
      logic [1:0] pending;
      range_type  next_range;
      logic       bad;
   } utf8_state_type;

   localparam utf8_state_type UTF8_IDLE = '{pending: 2'd0, next_range: RANGE_80_BF, bad: 1'b0};

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_ZERO_LEN   = 3'd1;
   localparam logic [2:0] STATUS_TOO_LARGE  = 3'd2;
   localparam logic [2:0] STATUS_BAD_UTF8   = 3'd3;
   localparam logic [2:0] STATUS_FAILED     = 3'd4;

   localparam int HEADER_BITS = 24;
   localparam logic [1:0] HEADER_LAST = 2'd3;

endpackage

### hdl/lpud_utf8.sv
// One step of the strict UTF-8 decoder: take a byte, give the next state.
module lpud_utf8 (
   input  lpud_pkg::utf8_state_type cur,
   input  logic [7:0]               data,
   output lpud_pkg::utf8_state_type nxt
);

   logic cont_ok;

   always_comb begin
      case (cur.next_range)
         lpud_pkg::RANGE_A0_BF: cont_ok = (data >= 8'hA0) && (data <= 8'hBF);
         lpud_pkg::RANGE_80_9F: cont_ok = (data >= 8'h80) && (data <= 8'h9F);
         lpud_pkg::RANGE_90_BF: cont_ok = (data >= 8'h90) && (data <= 8'hBF);
         lpud_pkg::RANGE_80_8F: cont_ok = (data >= 8'h80) && (data <= 8'h8F);
         default:               cont_ok = (data >= 8'h80) && (data <= 8'hBF);
      endcase
   end

   always_comb begin
      nxt            = cur;
      nxt.next_range = lpud_pkg::RANGE_80_BF;
      if (cur.pending != 2'd0) begin
         // continuation expected: count down, or flag and restart idle
         if (cont_ok) begin
            nxt.pending = cur.pending - 2'd1;
         end else begin
            nxt.bad     = 1'b1;
            nxt.pending = 2'd0;
         end
      end else if (data < 8'h80) begin
         nxt.pending = 2'd0;
      end else if ((data >= 8'hC2) && (data <= 8'hDF)) begin
         nxt.pending = 2'd1;
      end else if (data == 8'hE0) begin
         nxt.pending    = 2'd2;
         nxt.next_range = lpud_pkg::RANGE_A0_BF;
      end else if (data == 8'hED) begin
         nxt.pending    = 2'd2;
         nxt.next_range = lpud_pkg::RANGE_80_9F;
      end else if ((data >= 8'hE1) && (data <= 8'hEF)) begin
         nxt.pending = 2'd2;
      end else if (data == 8'hF0) begin
         nxt.pending    = 2'd3;
         nxt.next_range = lpud_pkg::RANGE_90_BF;
      end else if ((data >= 8'hF1) && (data <= 8'hF3)) begin
         nxt.pending = 2'd3;
      end else if (data == 8'hF4) begin
         nxt.pending    = 2'd3;
         nxt.next_range = lpud_pkg::RANGE_80_8F;
      end else begin
         nxt.bad = 1'b1;
      end
   end

endmodule

### hdl/length_prefixed_utf8_deframer_core.sv
// Length-prefixed frame deframer with strict UTF-8 payload checking.
//
// req_*  : one raw stream byte per word. Each frame is a 4-byte big-endian
//          length followed by that many payload bytes.
// rsp_*  : one result word per input word. tdata carries the echoed payload
//          byte and the frame status, tuser the byte kind (header, payload,
//          discarded), tlast marks the last payload byte of a frame.
// csr_*  : write the largest accepted payload length; write only while idle.
//
// Latency is two register stages: an accepted word passes the input register
// and then the result register, whose valid bit drives rsp_tvalid.
// The stages are an input register, then one pass of decode (32-bit length
// compare, remaining-count decrement, UTF-8 step) into the result register.
// Throughput is one word per cycle while the receiver keeps rsp_tready high.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; req_tready falls only when both are full.
// Reset clears both stages, the frame state and the failed flag, and loads
// the length limit with its default. After a length or UTF-8 error every
// later word is discarded with status "already failed" until reset.
module length_prefixed_utf8_deframer_core #(
   parameter logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] data_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [7:0] payload_byte, [10:8] frame_status, [15:11] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // rsp_tuser: [1:0] byte_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   // Configuration
   logic [31:0] max_len_ff;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Frame state
   logic [lpud_pkg::HEADER_BITS-1:0] header_shift_ff, header_shift_in;
   logic [1:0]                       header_count_ff, header_count_in;
   logic [31:0]                      remaining_ff, remaining_in;
   lpud_pkg::utf8_state_type         utf8_ff, utf8_in, utf8_step;
   logic                             failed_ff, failed_in;

   // Result register
   logic       out_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic       out_last_ff, out_last_in;
   logic [2:0] out_status_ff, out_status_in;

   logic        advance;
   logic [31:0] frame_len;

   // Advance the decode stage whenever the input register holds a word and the result register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign frame_len = {header_shift_ff, in_byte_ff};

   lpud_utf8 u_utf8 (
      .cur  (utf8_ff),
      .data (in_byte_ff),
      .nxt  (utf8_step)
   );

   always_comb begin
      header_shift_in = header_shift_ff;
      header_count_in = header_count_ff;
      remaining_in    = remaining_ff;
      utf8_in         = utf8_ff;
      failed_in       = failed_ff;
      out_byte_in     = 8'd0;
      out_kind_in     = lpud_pkg::KIND_HEADER;
      out_last_in     = 1'b0;
      out_status_in   = lpud_pkg::STATUS_OK;

      if (failed_ff) begin
         // sticky failure: drop everything
         out_kind_in   = lpud_pkg::KIND_DISCARD;
         out_status_in = lpud_pkg::STATUS_FAILED;
      end else if (remaining_ff == 32'd0) begin
         if (header_count_ff != lpud_pkg::HEADER_LAST) begin
            header_shift_in = {header_shift_ff[lpud_pkg::HEADER_BITS-9:0], in_byte_ff};
            header_count_in = header_count_ff + 2'd1;
         end else begin
            // fourth header byte: check the length, zero before the limit
            header_shift_in = '0;
            header_count_in = 2'd0;
            utf8_in         = lpud_pkg::UTF8_IDLE;
            if (frame_len == 32'd0) begin
               out_status_in = lpud_pkg::STATUS_ZERO_LEN;
               failed_in     = 1'b1;
            end else if (frame_len > max_len_ff) begin
               out_status_in = lpud_pkg::STATUS_TOO_LARGE;
               failed_in     = 1'b1;
            end else begin
               remaining_in = frame_len;
            end
         end
      end else begin
         out_kind_in  = lpud_pkg::KIND_PAYLOAD;
         out_byte_in  = in_byte_ff;
         utf8_in      = utf8_step;
         remaining_in = remaining_ff - 32'd1;
         if (remaining_ff == 32'd1) begin
            // last payload byte: report the UTF-8 verdict, reset the decoder
            out_last_in = 1'b1;
            utf8_in     = lpud_pkg::UTF8_IDLE;
            if (utf8_step.bad || (utf8_step.pending != 2'd0)) begin
               out_status_in = lpud_pkg::STATUS_BAD_UTF8;
               failed_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_shift_ff <= '0;
         header_count_ff <= 2'd0;
         remaining_ff    <= 32'd0;
         utf8_ff         <= lpud_pkg::UTF8_IDLE;
         failed_ff       <= 1'b0;
      end else if (advance) begin
         header_shift_ff <= header_shift_in;
         header_count_ff <= header_count_in;
         remaining_ff    <= remaining_in;
         utf8_ff         <= utf8_in;
         failed_ff       <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff   <= out_byte_in;
         out_kind_ff   <= out_kind_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_status_ff, out_byte_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // Once failed, stay failed until reset.
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("failed flag dropped without reset");

   // A partly gathered header only exists outside a payload.
   a_header_outside_payload: assert property (@(posedge clock) disable iff (reset)
      (header_count_ff != 2'd0) |-> (remaining_ff == 32'd0))
      else $error("header bytes gathered during payload");

   // The UTF-8 decoder is only mid-sequence while payload remains.
   a_utf8_in_payload: assert property (@(posedge clock) disable iff (reset)
      (utf8_ff.pending != 2'd0) |-> (remaining_ff != 32'd0))
      else $error("UTF-8 sequence open outside payload");

   // Frame end marks only payload words.
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_kind_ff == lpud_pkg::KIND_PAYLOAD))
      else $error("frame end on a non-payload word");

   // Discarded words always carry the already-failed status.
   a_discard_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == lpud_pkg::KIND_DISCARD))
         |-> (out_status_ff == lpud_pkg::STATUS_FAILED))
      else $error("discarded word without failed status");

endmodule
